// ----- rtl/vlen_pkg.sv -----
// package: shared types, constants and register codes for the variable-length integer narrower
`timescale 1ns / 1ps

package vlen_pkg;

	// widest destination integer in bytes
	localparam int MAX_RESULT_BYTES = 8;
	localparam int VALUE_W          = 64;
	localparam int CFG_IDX_W        = 8;
	localparam int CFG_DATA_W       = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_BYTES = 8'd0,
		REG_SIGNED_MODE  = 8'd1
	} reg_idx_t;

	// one input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       no_bytes;
	} item_t;

	// one result item
	typedef struct packed {
		logic [VALUE_W-1:0] value_bits;
		logic               format_ok;
	} result_t;

	// configuration register contents
	typedef struct packed {
		logic [3:0] target_bytes;
		logic       signed_mode;
	} cfg_t;

endpackage

// ----- rtl/vlen_if.sv -----
// interfaces: input item, result item and configuration write channels
`timescale 1ns / 1ps

interface vlen_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       no_bytes;

	modport source (output valid, data_byte, last_byte, no_bytes, input ready);
	modport sink (input valid, data_byte, last_byte, no_bytes, output ready);
endinterface

interface vlen_result_if;
	logic                          valid;
	logic                          ready;
	logic [vlen_pkg::VALUE_W-1:0]  value_bits;
	logic                          format_ok;

	modport source (output valid, value_bits, format_ok, input ready);
	modport sink (input valid, value_bits, format_ok, output ready);
endinterface

interface vlen_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vlen_pkg::CFG_IDX_W-1:0]  index;
	logic [vlen_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/vlen_cfg.sv -----
// configuration registers: destination width and signedness
`timescale 1ns / 1ps

module vlen_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [vlen_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [vlen_pkg::CFG_DATA_W-1:0] wr_data,
	output vlen_pkg::cfg_t cfg
);

	vlen_pkg::cfg_t cfg_q;

	// register decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_bytes <= 4'd4;
			cfg_q.signed_mode  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				vlen_pkg::REG_TARGET_BYTES: cfg_q.target_bytes <= wr_data[3:0];
				vlen_pkg::REG_SIGNED_MODE:  cfg_q.signed_mode  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/vlen_acc.sv -----
// accumulator stage: gathers bytes, checks extension bytes and forms the result
`timescale 1ns / 1ps

module vlen_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  vlen_pkg::item_t   item,
	input  vlen_pkg::cfg_t    cfg,
	output logic              finish,
	output vlen_pkg::result_t res
);

	localparam logic [3:0] MAX_BYTES = 4'(vlen_pkg::MAX_RESULT_BYTES);
	localparam logic [3:0] COUNT_SAT = 4'd9;

	logic [vlen_pkg::VALUE_W-1:0] acc_q;
	logic [3:0]                   count_q;
	logic                         ovf_q;

	logic [3:0]                   width;
	logic [2:0]                   width_m1;
	logic                         sign_bit;
	logic [7:0]                   fill_byte;
	logic [vlen_pkg::VALUE_W-1:0] acc_add;
	logic [vlen_pkg::VALUE_W-1:0] acc_next;
	logic [3:0]                   count_next;
	logic                         ovf_next;
	logic [vlen_pkg::VALUE_W-1:0] fin_acc;
	logic [3:0]                   fin_count;
	logic                         fin_ovf;
	logic [3:0]                   keep;
	logic [2:0]                   keep_m1;
	logic                         ext_bit;
	logic [vlen_pkg::VALUE_W-1:0] ext_val;

	// effective destination width, clamped to 1..max
	always_comb begin
		if (cfg.target_bytes == 4'd0)
			width = 4'd1;
		else if (cfg.target_bytes > MAX_BYTES)
			width = MAX_BYTES;
		else
			width = cfg.target_bytes;
		width_m1 = 3'(width - 4'd1);
	end

	// byte placement and extension byte check
	always_comb begin
		acc_add = '0;
		for (int i = 0; i < vlen_pkg::MAX_RESULT_BYTES; i++) begin
			if (count_q == 4'(i) && count_q < width)
				acc_add[8*i +: 8] = item.data_byte;
		end
		acc_next   = acc_q | acc_add;
		sign_bit   = acc_q[{width_m1, 3'b111}];
		fill_byte  = (cfg.signed_mode && sign_bit) ? 8'hFF : 8'h00;
		ovf_next   = ovf_q | ((count_q >= width) && (item.data_byte != fill_byte));
		count_next = (count_q < COUNT_SAT) ? count_q + 4'd1 : count_q;
	end

	// zero-length mark closes the value on the state gathered so far; a last byte closes it with that byte included
	always_comb begin
		finish = item.no_bytes | item.last_byte;
		if (item.no_bytes) begin
			fin_acc   = acc_q;
			fin_count = count_q;
			fin_ovf   = ovf_q;
		end else begin
			fin_acc   = acc_next;
			fin_count = count_next;
			fin_ovf   = ovf_next;
		end
	end

	// sign extension from the last kept byte, per byte lane
	always_comb begin
		keep    = (fin_count < width) ? fin_count : width;
		keep_m1 = 3'(keep - 4'd1);
		ext_bit = fin_acc[{keep_m1, 3'b111}];
		ext_val = fin_acc;
		if (cfg.signed_mode && keep != 4'd0 && keep < 4'(vlen_pkg::VALUE_W / 8)) begin
			for (int i = 0; i < vlen_pkg::VALUE_W / 8; i++) begin
				if (4'(i) >= keep)
					ext_val[8*i +: 8] = {8{ext_bit}};
			end
		end
		res.value_bits = fin_ovf ? '0 : ext_val;
		res.format_ok  = ~fin_ovf;
	end

	// value state, cleared after each finished value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (step_en) begin
			if (finish) begin
				acc_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				acc_q   <= acc_next;
				count_q <= count_next;
				ovf_q   <= ovf_next;
			end
		end
	end

endmodule

// ----- rtl/var_length_le_integer_narrower_top.sv -----
// A result is registered once the transaction carrying the final byte leaves the input
// register. Throughput: one byte per cycle unless a finishing byte waits on a full
// result register, set by the single accumulator update stage between the registers.
// Reset: clears the accumulator, byte count and overflow flag, empties both
// registers, and sets target_bytes to 4 and signed_mode to 0.
`timescale 1ns / 1ps

module var_length_le_integer_narrower_top (
	input  logic         clk,
	input  logic         arst_n,
	vlen_item_if.sink    item,
	vlen_result_if.source result,
	vlen_cfg_if.sink     cfg
);

	vlen_pkg::cfg_t    cfg_w;
	vlen_pkg::item_t   item_s1;
	vlen_pkg::result_t res_w;
	vlen_pkg::result_t res_q;
	logic              s1_valid_s1;
	logic              out_valid_q;
	logic              s1_fin;
	logic              s1_adv;
	logic              out_free;
	logic              item_acc;

	// configuration channel is always ready
	assign cfg.ready = 1'b1;

	vlen_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_w)
	);

	// handshake control
	assign out_free   = ~out_valid_q | result.ready;
	assign s1_adv     = s1_valid_s1 & (~s1_fin | out_free);
	assign item.ready = ~s1_valid_s1 | s1_adv;
	assign item_acc   = item.valid & item.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (item_acc) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1.data_byte <= item.data_byte;
			item_s1.last_byte <= item.last_byte;
			item_s1.no_bytes  <= item.no_bytes;
		end
	end

	vlen_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (s1_adv),
		.item    (item_s1),
		.cfg     (cfg_w),
		.finish  (s1_fin),
		.res     (res_w)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_fin) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_fin)
			res_q <= res_w;
	end

	assign result.valid      = out_valid_q;
	assign result.value_bits = res_q.value_bits;
	assign result.format_ok  = res_q.format_ok;

	// a finishing item stalled behind a full result register blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && s1_fin && !out_free) |-> !item.ready)
		else $error("input accepted while finishing item is stalled");

	// a finishing item always lands in the result register
	a_fin_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_fin) |=> result.valid)
		else $error("finished value lost");

	// failed conversions carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.format_ok) |-> (result.value_bits == '0))
		else $error("overflow result with nonzero value");

endmodule
